// ===== src/mpic_pkg.sv =====
// ----------------------------------------------------------------------------
// mpic_pkg: shared types and constants for the interrupt controller
// Word formats, command and register codes, and the request struct.
// ----------------------------------------------------------------------------
package mpic_pkg;

    localparam int unsigned PRIO_W = 3;
    localparam int unsigned NUM_SRC = 8;

    localparam logic [15:0] MASK_KEEP  = 16'h007F;
    localparam logic [15:0] MASK_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_LINE    = 2'd0,
        CMD_RD_HALF = 2'd1,
        CMD_RD_BYTE = 2'd2,
        CMD_WR_HALF = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_PENDING = 2'd0,
        REG_MASK    = 2'd1,
        REG_PRIO_LO = 2'd2,
        REG_PRIO_HI = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  source_index;
        logic        assert_level;
        logic [7:0]  address;
        logic [15:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_active;
        logic [3:0]  irq_level;
    } t_out_word;

    typedef struct packed {
        logic        active;
        logic [3:0]  level;
    } t_irq;

endpackage

// ===== src/mpic_resolve.sv =====
// ----------------------------------------------------------------------------
// mpic_resolve: interrupt request resolution
// Picks the highest priority among pending, unmasked sources.
// ----------------------------------------------------------------------------
module mpic_resolve
    import mpic_pkg::*;
(
    input  logic [NUM_SRC-1:0] i_pending,
    input  logic [NUM_SRC-1:0] i_mask,
    input  logic [11:0]        i_prio_lo,
    input  logic [8:0]         i_prio_hi,
    output t_irq               o_irq
);

    logic [NUM_SRC-1:0] w_live;
    logic [PRIO_W-1:0]  w_prio [NUM_SRC];
    logic [PRIO_W-1:0]  w_best;
    logic               w_any;

    assign w_live = i_pending & ~i_mask;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            w_prio[b] = i_prio_lo[b*PRIO_W +: PRIO_W];
        end
        for (int b = 4; b < 7; b++) begin
            w_prio[b] = i_prio_hi[(b-4)*PRIO_W +: PRIO_W];
        end
        w_prio[7] = '0;
    end

    always_comb begin
        w_best = '0;
        w_any  = 1'b0;
        for (int b = 0; b < NUM_SRC; b++) begin
            if (w_live[b] && (w_prio[b] > w_best)) begin
                w_best = w_prio[b];
            end
            if (w_live[b]) begin
                w_any = 1'b1;
            end
        end
    end

    assign o_irq.active = w_any;
    assign o_irq.level  = {1'b1, w_best};

endmodule

// ===== src/masked_priority_interrupt_controller_core.sv =====
// ----------------------------------------------------------------------------
// masked_priority_interrupt_controller_core: eight-source interrupt controller
// Throughput: one word per cycle unless i_stall holds a full result register;
// each word passes the input register, then one pass of decode, state update
// and priority resolution, then the result register.
// Reset: pending and priorities clear, mask set to all ones, both stages empty.
// ----------------------------------------------------------------------------
module masked_priority_interrupt_controller_core
    import mpic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    logic         r_in_valid;
    t_in_word     r_in;
    logic         r_out_valid;
    t_out_word    r_out;

    logic [7:0]   r_pending, n_pending;
    logic [15:0]  r_mask, n_mask;
    logic [11:0]  r_prio_lo, n_prio_lo;
    logic [8:0]   r_prio_hi, n_prio_hi;

    logic         w_out_free;
    logic         w_adv;
    logic [15:0]  w_reg_val;
    logic [15:0]  w_rd;
    t_reg_sel     w_sel;
    t_irq         w_irq;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_sel      = t_reg_sel'(r_in.address[7:6]);

    always_comb begin
        case (w_sel)
            REG_PENDING: w_reg_val = {8'h00, r_pending};
            REG_MASK:    w_reg_val = r_mask;
            REG_PRIO_LO: w_reg_val = {4'h0, r_prio_lo};
            REG_PRIO_HI: w_reg_val = {7'h00, r_prio_hi};
            default:     w_reg_val = '0;
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        n_mask    = r_mask;
        n_prio_lo = r_prio_lo;
        n_prio_hi = r_prio_hi;
        w_rd      = '0;
        case (t_cmd'(r_in.cmd))
            CMD_LINE: begin
                n_pending[~r_in.source_index] = r_in.assert_level;
            end
            CMD_RD_HALF: begin
                w_rd = w_reg_val;
            end
            CMD_RD_BYTE: begin
                w_rd = {8'h00, r_in.address[0] ? w_reg_val[15:8] : w_reg_val[7:0]};
            end
            CMD_WR_HALF: begin
                case (w_sel)
                    REG_MASK: begin
                        n_mask = r_in.write_data & MASK_KEEP;
                    end
                    REG_PRIO_LO: begin
                        if (r_mask == MASK_KEEP) begin
                            n_prio_lo = r_in.write_data[11:0];
                        end
                    end
                    REG_PRIO_HI: begin
                        if (r_mask == MASK_KEEP) begin
                            n_prio_hi = r_in.write_data[8:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    mpic_resolve u_resolve (
        .i_pending (n_pending),
        .i_mask    (n_mask[7:0]),
        .i_prio_lo (n_prio_lo),
        .i_prio_hi (n_prio_hi),
        .o_irq     (w_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_mask      <= MASK_RESET;
            r_prio_lo   <= '0;
            r_prio_hi   <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_pending <= n_pending;
                r_mask    <= n_mask;
                r_prio_lo <= n_prio_lo;
                r_prio_hi <= n_prio_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
        if (w_adv) begin
            r_out.read_data  <= w_rd;
            r_out.irq_active <= w_irq.active;
            r_out.irq_level  <= w_irq.level;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_level_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.irq_level[3])
        else $error("request level below base");

    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.irq_active) |-> (o_data.irq_level == 4'd8))
        else $error("idle request level not base");

    a_mask_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask[15:7] == 9'h000) || (r_mask[15:7] == 9'h1FF))
        else $error("mask upper bits inconsistent");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_pending) && $stable(r_mask)
                    && $stable(r_prio_lo) && $stable(r_prio_hi)))
        else $error("state changed without a word");

endmodule

// ===== test/masked_priority_interrupt_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// masked_priority_interrupt_controller_core_tb: self-checking bench for the core
// Sends line events, register reads and register writes through the input
// channel and checks every result word against a cycle-free model of the
// controller state. Covers the reset state, the mask and priority unlock,
// sources that cannot be masked, an output hold that fills the pipeline, and
// a long random run with random idling on both channels.
// ----------------------------------------------------------------------------
module masked_priority_interrupt_controller_core_tb;
    import mpic_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 900;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_data;

    logic [7:0]  exp_pending;
    logic [15:0] exp_mask;
    logic [11:0] exp_prio_lo;
    logic [8:0]  exp_prio_hi;

    t_out_word awaited_words[$];
    bit        tx_idle = 1'b1;
    logic      rx_idle = 1'b1;
    logic      rx_hold = 1'b0;
    int        rx_wait = 0;
    int        quiet_cycles = 0;
    int        words_sent = 0;
    int        results_checked = 0;
    int        fails = 0;

    masked_priority_interrupt_controller_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_out_word predict_response(input t_in_word w);
        t_out_word  r;
        logic [15:0] rv;
        logic [7:0]  bit_sel;
        logic [7:0]  live;
        logic [2:0]  p;
        logic [2:0]  best;
        logic        any;
        r = '0;
        case (t_reg_sel'(w.address[7:6]))
            REG_PENDING: rv = {8'h00, exp_pending};
            REG_MASK:    rv = exp_mask;
            REG_PRIO_LO: rv = {4'h0, exp_prio_lo};
            default:     rv = {7'h00, exp_prio_hi};
        endcase
        case (t_cmd'(w.cmd))
            CMD_LINE: begin
                bit_sel = 8'h80 >> w.source_index;
                exp_pending = w.assert_level ? (exp_pending | bit_sel)
                                             : (exp_pending & ~bit_sel);
            end
            CMD_RD_HALF: r.read_data = rv;
            CMD_RD_BYTE: r.read_data = w.address[0] ? {8'h00, rv[15:8]} : {8'h00, rv[7:0]};
            default: begin
                case (t_reg_sel'(w.address[7:6]))
                    REG_MASK: exp_mask = w.write_data & MASK_KEEP;
                    REG_PRIO_LO: if (exp_mask == MASK_KEEP) exp_prio_lo = w.write_data[11:0];
                    REG_PRIO_HI: if (exp_mask == MASK_KEEP) exp_prio_hi = w.write_data[8:0];
                    default: ;
                endcase
            end
        endcase
        live = exp_pending & ~exp_mask[7:0];
        best = '0;
        any  = 1'b0;
        for (int b = 0; b < NUM_SRC; b++) begin
            if (live[b]) begin
                if (b < 4)
                    p = exp_prio_lo[3*b +: 3];
                else if (b < 7)
                    p = exp_prio_hi[3*(b-4) +: 3];
                else
                    p = '0;
                if (p > best) best = p;
                any = 1'b1;
            end
        end
        r.irq_active = any;
        r.irq_level  = {1'b1, best};
        return r;
    endfunction

    function automatic t_in_word line_word(input logic [2:0] src, input logic lvl);
        t_in_word w;
        w = t_in_word'(30'($urandom));
        w.cmd = CMD_LINE;
        w.source_index = src;
        w.assert_level = lvl;
        return w;
    endfunction

    function automatic t_in_word bus_word(input t_cmd c, input t_reg_sel r, input logic b0,
                                          input logic [15:0] d);
        t_in_word w;
        w = t_in_word'(30'($urandom));
        w.cmd = c;
        w.address[7:6] = r;
        w.address[0] = b0;
        w.write_data = d;
        return w;
    endfunction

    function automatic t_in_word random_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return line_word(3'($urandom), 1'($urandom));
            4, 5: return bus_word(CMD_RD_HALF, t_reg_sel'($urandom_range(0, 3)),
                                  1'($urandom), 16'($urandom));
            6, 7: return bus_word(CMD_RD_BYTE, t_reg_sel'($urandom_range(0, 3)),
                                  1'($urandom), 16'($urandom));
            default: return bus_word(CMD_WR_HALF, t_reg_sel'($urandom_range(0, 3)),
                                     1'($urandom), 16'($urandom));
        endcase
    endfunction

    task automatic issue_word(input t_in_word w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            i_valid <= 1'b0;
            i_data  <= t_in_word'(30'($urandom));
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        awaited_words.push_back(predict_response(w));
        words_sent++;
    endtask

    always @(posedge i_clk) begin : rx_side
        int n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            n = rx_idle ? $urandom_range(0, 7) : 0;
            rx_wait <= (n != 0) ? n - 1 : 0;
            i_stall <= (n != 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_words.size() == 0) begin
                $error("result word with nothing awaited: %h", o_data);
                fails++;
            end else begin
                e = awaited_words.pop_front();
                results_checked++;
                if (o_data.read_data !== e.read_data) begin
                    $error("read_data: expected %h, got %h", e.read_data, o_data.read_data);
                    fails++;
                end
                if (o_data.irq_active !== e.irq_active) begin
                    $error("irq_active: expected %0d, got %0d", e.irq_active, o_data.irq_active);
                    fails++;
                end
                if (o_data.irq_level !== e.irq_level) begin
                    $error("irq_level: expected %0d, got %0d", e.irq_level, o_data.irq_level);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_reset_values();
        issue_word(bus_word(CMD_RD_HALF, REG_PENDING, 1'b1, 16'($urandom)));
        issue_word(bus_word(CMD_RD_HALF, REG_MASK, 1'b0, 16'($urandom)));
        issue_word(bus_word(CMD_RD_BYTE, REG_MASK, 1'b0, 16'($urandom)));
        issue_word(bus_word(CMD_RD_BYTE, REG_MASK, 1'b1, 16'($urandom)));
        issue_word(bus_word(CMD_WR_HALF, REG_PRIO_LO, 1'b0, 16'hFFFF));
        issue_word(bus_word(CMD_RD_HALF, REG_PRIO_LO, 1'b0, 16'h0000));
        issue_word(bus_word(CMD_WR_HALF, REG_PENDING, 1'b1, 16'hFFFF));
        issue_word(line_word(3'd0, 1'b1));
    endtask

    task automatic test_unmask_and_priorities();
        issue_word(bus_word(CMD_WR_HALF, REG_MASK, 1'b0, 16'hFFFF));
        issue_word(bus_word(CMD_WR_HALF, REG_PRIO_LO, 1'b1, 16'hFFFF));
        issue_word(bus_word(CMD_WR_HALF, REG_PRIO_HI, 1'b0, 16'hFFFF));
        issue_word(bus_word(CMD_RD_HALF, REG_PRIO_HI, 1'b1, 16'h0000));
        issue_word(bus_word(CMD_RD_BYTE, REG_PRIO_LO, 1'b1, 16'h0000));
        issue_word(line_word(3'd3, 1'b1));
        issue_word(bus_word(CMD_WR_HALF, REG_MASK, 1'b1, 16'h0000));
        issue_word(bus_word(CMD_WR_HALF, REG_PRIO_HI, 1'b0, 16'h0000));
        issue_word(line_word(3'd3, 1'b0));
        issue_word(line_word(3'd7, 1'b1));
        issue_word(line_word(3'd0, 1'b0));
        issue_word(line_word(3'd7, 1'b0));
        issue_word(bus_word(CMD_RD_BYTE, REG_PENDING, 1'b0, 16'hFFFF));
        issue_word(bus_word(CMD_WR_HALF, REG_MASK, 1'b0, 16'h0080));
        issue_word(bus_word(CMD_RD_HALF, REG_MASK, 1'b1, 16'h0000));
    endtask

    task automatic test_output_hold();
        tx_idle = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            repeat (40) issue_word(random_word());
        join
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if ((words_sent - start) % 120 < 4) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                // unlock, program both priority groups, then pick a fresh mask
                issue_word(bus_word(CMD_WR_HALF, REG_MASK, 1'($urandom),
                                    16'($urandom) | MASK_KEEP));
                issue_word(bus_word(CMD_WR_HALF, REG_PRIO_LO, 1'($urandom), 16'($urandom)));
                issue_word(bus_word(CMD_WR_HALF, REG_PRIO_HI, 1'($urandom), 16'($urandom)));
                issue_word(bus_word(CMD_WR_HALF, REG_MASK, 1'($urandom),
                                    16'($urandom & $urandom)));
            end else begin
                issue_word(random_word());
            end
        end
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
    endtask

    initial begin
        exp_pending = '0;
        exp_mask    = MASK_RESET;
        exp_prio_lo = '0;
        exp_prio_hi = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_unmask_and_priorities();
        test_output_hold();
        test_random_traffic();
        i_valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Summary: %0d words sent, %0d results compared", words_sent, results_checked);
        $display("Covered line events, both read widths, priority writes and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== masked_priority_interrupt_controller_core.f =====
src/mpic_pkg.sv
src/mpic_resolve.sv
src/masked_priority_interrupt_controller_core.sv
test/masked_priority_interrupt_controller_core_tb.sv
